/* rtl/gmma_pkg.sv */
// gmma_pkg: widths, codes and the control store of the greedy matching block
// depends on nothing; used by gmma_ram users and greedy_match_masked_argmax
`timescale 1ns / 1ps

package gmma_pkg;

    // field widths
    localparam int SCORE_FRAC_BITS = 15;
    localparam int SCORE_W         = SCORE_FRAC_BITS + 2;
    localparam int INDEX_W         = 4;
    localparam int OPCODE_W        = 3;
    localparam int KIND_W          = 2;
    localparam int CNT_W           = 5;
    localparam int CFG_INDEX_W     = 2;

    // default geometry
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    // longest free list given for one item
    localparam int LIST_LIMIT  = 16;
    localparam int LIST_CNT_W  = $clog2(LIST_LIMIT + 1);

    // reset values of the registers, floor is minus one in q2.15
    localparam logic [CNT_W-1:0]   ROWS_RESET  = CNT_W'(16);
    localparam logic [CNT_W-1:0]   COLS_RESET  = CNT_W'(16);
    localparam logic [SCORE_W-1:0] FLOOR_RESET = {2'b11, {SCORE_FRAC_BITS{1'b0}}};

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR = 2'd2;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_TAKE      = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_BEST      = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_FREE_ROWS = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FREE_COLS = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_TAKE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEST     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE_ROW = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FREE_COL = 2'd3;

    // sequencer step addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] PC_WRITE     = 4'd1;
    localparam logic [PC_W-1:0] PC_TAKE      = 4'd2;
    localparam logic [PC_W-1:0] PC_BEST_INIT = 4'd3;
    localparam logic [PC_W-1:0] PC_SCAN      = 4'd4;
    localparam logic [PC_W-1:0] PC_BEST_EMIT = 4'd5;
    localparam logic [PC_W-1:0] PC_LIST_INIT = 4'd6;
    localparam logic [PC_W-1:0] PC_LIST_STEP = 4'd7;
    localparam logic [PC_W-1:0] PC_LIST_END  = 4'd8;
    localparam logic [PC_W-1:0] PC_CLR_INIT  = 4'd9;
    localparam logic [PC_W-1:0] PC_CLR_SWEEP = 4'd10;

    // next-step modes
    localparam logic [1:0] NX_SEQ  = 2'd0;
    localparam logic [1:0] NX_JUMP = 2'd1;
    localparam logic [1:0] NX_DISP = 2'd2;
    localparam logic [1:0] NX_LOOP = 2'd3;

    // loop exit conditions
    localparam logic [1:0] COND_NONE      = 2'd0;
    localparam logic [1:0] COND_SCAN_DONE = 2'd1;
    localparam logic [1:0] COND_LIST_DONE = 2'd2;
    localparam logic [1:0] COND_SWEEP_END = 2'd3;

    // datapath actions
    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_TAKE      = 4'd2;
    localparam logic [ACT_W-1:0] ACT_BEST_INIT = 4'd3;
    localparam logic [ACT_W-1:0] ACT_SCAN      = 4'd4;
    localparam logic [ACT_W-1:0] ACT_BEST_EMIT = 4'd5;
    localparam logic [ACT_W-1:0] ACT_LIST_INIT = 4'd6;
    localparam logic [ACT_W-1:0] ACT_LIST_STEP = 4'd7;
    localparam logic [ACT_W-1:0] ACT_LIST_END  = 4'd8;
    localparam logic [ACT_W-1:0] ACT_CLR_INIT  = 4'd9;
    localparam logic [ACT_W-1:0] ACT_CLR_SWEEP = 4'd10;

    typedef struct packed {
        logic [1:0]       nxt;
        logic [1:0]       cond;
        logic [ACT_W-1:0] act;
        logic [PC_W-1:0]  target;
    } t_uword;

    // control store
    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        w.nxt    = NX_JUMP;
        w.cond   = COND_NONE;
        w.act    = ACT_NONE;
        w.target = PC_IDLE;
        unique case (pc)
            PC_IDLE: begin
                w.nxt = NX_DISP;
            end
            PC_WRITE: begin
                w.act = ACT_WRITE;
            end
            PC_TAKE: begin
                w.act = ACT_TAKE;
            end
            PC_BEST_INIT: begin
                w.act = ACT_BEST_INIT;
                w.nxt = NX_SEQ;
            end
            PC_SCAN: begin
                w.act    = ACT_SCAN;
                w.nxt    = NX_LOOP;
                w.cond   = COND_SCAN_DONE;
                w.target = PC_BEST_EMIT;
            end
            PC_BEST_EMIT: begin
                w.act = ACT_BEST_EMIT;
            end
            PC_LIST_INIT: begin
                w.act = ACT_LIST_INIT;
                w.nxt = NX_SEQ;
            end
            PC_LIST_STEP: begin
                w.act    = ACT_LIST_STEP;
                w.nxt    = NX_LOOP;
                w.cond   = COND_LIST_DONE;
                w.target = PC_LIST_END;
            end
            PC_LIST_END: begin
                w.act = ACT_LIST_END;
            end
            PC_CLR_INIT: begin
                w.act = ACT_CLR_INIT;
                w.nxt = NX_SEQ;
            end
            PC_CLR_SWEEP: begin
                w.act    = ACT_CLR_SWEEP;
                w.nxt    = NX_LOOP;
                w.cond   = COND_SWEEP_END;
                w.target = PC_IDLE;
            end
            default: begin
                w.act = ACT_NONE;
            end
        endcase
        return w;
    endfunction

    // entry step of each opcode
    function automatic logic [PC_W-1:0] dispatch(input logic [OPCODE_W-1:0] op);
        logic [PC_W-1:0] pc;
        pc = PC_IDLE;
        unique case (op) inside
            OP_WRITE:                   pc = PC_WRITE;
            OP_TAKE:                    pc = PC_TAKE;
            OP_BEST:                    pc = PC_BEST_INIT;
            OP_FREE_ROWS, OP_FREE_COLS: pc = PC_LIST_INIT;
            OP_CLEAR:                   pc = PC_CLR_INIT;
            default:                    pc = PC_IDLE;
        endcase
        return pc;
    endfunction

endpackage

/* rtl/greedy_match_masked_argmax.sv */
// Score matrix for greedy matching with a taken mark per row and per column. Items carry an
// opcode: write one score, take a row and column pair (acknowledged with whether both indices
// lie in the rows and columns in use), find the first strict maximum over the untaken part in
// row-major order (or found low with the floor score), list the untaken rows or columns (one
// result each, last marked, at most sixteen; an empty list gives one result with found low),
// and clear (fill with the floor score, clear the marks). Items are taken one at a time; a
// result waits in an output register, so the next item is accepted while it waits. The best
// pair search reads one stored score per cycle through the single read port of the score ram,
// and a free list step or any other result waits while the output register is full. After
// reset a clearing pass fills the ram; no item is accepted meanwhile. Register writes are
// always taken; the user must keep them to idle periods, as the block does not enforce it.
//
// greedy_match_masked_argmax: top level, microcoded sequencer with plain datapath
// depends on gmma_pkg and gmma_ram
`timescale 1ns / 1ps

module greedy_match_masked_argmax #(
    parameter int MAX_ROWS = gmma_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gmma_pkg::DEF_MAX_COLS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // register write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gmma_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [gmma_pkg::SCORE_W-1:0]          i_cfg_data,
    // item channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [gmma_pkg::OPCODE_W-1:0]         i_opcode,
    input  logic [gmma_pkg::INDEX_W-1:0]          i_row_index,
    input  logic [gmma_pkg::INDEX_W-1:0]          i_col_index,
    input  logic signed [gmma_pkg::SCORE_W-1:0]   i_score_in,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [gmma_pkg::KIND_W-1:0]           o_result_kind,
    output logic [gmma_pkg::INDEX_W-1:0]          o_out_row,
    output logic [gmma_pkg::INDEX_W-1:0]          o_out_col,
    output logic signed [gmma_pkg::SCORE_W-1:0]   o_out_score,
    output logic                                  o_found,
    output logic                                  o_accepted,
    output logic                                  o_last
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = gmma_pkg::CNT_W;
    localparam int SW    = gmma_pkg::SCORE_W;
    localparam int IW    = gmma_pkg::INDEX_W;
    localparam int KW    = gmma_pkg::LIST_CNT_W;

    // sequencer
    logic [gmma_pkg::PC_W-1:0] r_pc;
    logic [gmma_pkg::PC_W-1:0] n_pc;
    gmma_pkg::t_uword          uw;

    // registers
    logic [NW-1:0]        r_rows;
    logic [NW-1:0]        r_cols;
    logic signed [SW-1:0] r_floor;

    // latched item
    logic [gmma_pkg::OPCODE_W-1:0] r_op;
    logic [IW-1:0]                 r_row;
    logic [IW-1:0]                 r_col;
    logic signed [SW-1:0]          r_score;

    // marks
    logic [MAX_ROWS-1:0] r_row_taken;
    logic [MAX_COLS-1:0] r_col_taken;

    // loop counters
    logic [NW-1:0] r_i;
    logic [NW-1:0] r_j;
    logic [KW-1:0] r_k;
    logic [AW-1:0] r_addr;

    // scan compare stage and running best
    logic                 r_pv;
    logic [IW-1:0]        r_pi;
    logic [IW-1:0]        r_pj;
    logic signed [SW-1:0] r_best;
    logic [IW-1:0]        r_br;
    logic [IW-1:0]        r_bc;
    logic                 r_hit;

    // output register
    logic                 r_out_valid;
    logic [gmma_pkg::KIND_W-1:0] r_kind;
    logic [IW-1:0]        r_orow;
    logic [IW-1:0]        r_ocol;
    logic signed [SW-1:0] r_oscore;
    logic                 r_found;
    logic                 r_acc;
    logic                 r_last;

    // combinational
    logic                 in_fire;
    logic [NW-1:0]        eff_rows;
    logic [NW-1:0]        eff_cols;
    logic [RW-1:0]        take_row;
    logic [CW-1:0]        take_col;
    logic                 take_ok;
    logic                 take_fire;
    logic                 wr_in_store;
    logic [AW-1:0]        wr_addr;
    logic [RW-1:0]        scan_row;
    logic [CW-1:0]        scan_col;
    logic [AW-1:0]        scan_addr;
    logic                 scan_done;
    logic                 cell_ok;
    logic                 j_last;
    logic                 list_col;
    logic [NW-1:0]        list_n;
    logic                 cur_free;
    logic                 row_more;
    logic                 col_more;
    logic                 list_done;
    logic                 sweep_end;
    logic                 cond_true;
    logic                 emit_want;
    logic                 out_free;
    logic                 stall;
    logic                 fire;
    logic [gmma_pkg::KIND_W-1:0] e_kind;
    logic [IW-1:0]        e_row;
    logic [IW-1:0]        e_col;
    logic signed [SW-1:0] e_score;
    logic                 e_found;
    logic                 e_acc;
    logic                 e_last;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SW-1:0]        ram_wdata;
    logic [SW-1:0]        ram_rdata;
    logic signed [SW-1:0] rd_score;

    assign uw          = gmma_pkg::uc_rom(r_pc);
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_pc == gmma_pkg::PC_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;

    // in-use counts saturate at the store size
    assign eff_rows = (int'(r_rows) > MAX_ROWS) ? NW'(MAX_ROWS) : r_rows;
    assign eff_cols = (int'(r_cols) > MAX_COLS) ? NW'(MAX_COLS) : r_cols;

    // take and write addressing
    assign take_row    = RW'(r_row);
    assign take_col    = CW'(r_col);
    assign take_ok     = (NW'(r_row) < eff_rows) && (NW'(r_col) < eff_cols);
    assign wr_in_store = (int'(r_row) < MAX_ROWS) && (int'(r_col) < MAX_COLS);
    assign wr_addr     = AW'(take_row) * AW'(MAX_COLS) + AW'(take_col);

    // scan addressing, one cell a cycle in row-major order
    assign scan_row  = RW'(r_i);
    assign scan_col  = CW'(r_j);
    assign scan_addr = AW'(scan_row) * AW'(MAX_COLS) + AW'(scan_col);
    assign scan_done = (r_i >= eff_rows) || (eff_cols == '0);
    assign cell_ok   = !r_row_taken[scan_row] && !r_col_taken[scan_col];
    assign j_last    = (r_j + NW'(1)) >= eff_cols;
    assign rd_score  = ram_rdata;

    // free list walk
    assign list_col = (r_op == gmma_pkg::OP_FREE_COLS);
    assign list_n   = list_col ? eff_cols : eff_rows;
    assign cur_free = (r_i < list_n) &&
                      (list_col ? !r_col_taken[CW'(r_i)] : !r_row_taken[RW'(r_i)]);
    assign list_done = (r_i >= list_n) || (r_k == KW'(gmma_pkg::LIST_LIMIT));

    // any free index beyond the current one, so the last result is known when given
    always_comb begin
        row_more = 1'b0;
        for (int k = 0; k < MAX_ROWS; k++) begin
            if (k > int'(r_i) && k < int'(eff_rows) && !r_row_taken[k]) begin
                row_more = 1'b1;
            end
        end
        col_more = 1'b0;
        for (int k = 0; k < MAX_COLS; k++) begin
            if (k > int'(r_i) && k < int'(eff_cols) && !r_col_taken[k]) begin
                col_more = 1'b1;
            end
        end
    end

    assign sweep_end = (r_addr == AW'(DEPTH - 1));

    always_comb begin
        unique case (uw.cond)
            gmma_pkg::COND_SCAN_DONE: cond_true = scan_done;
            gmma_pkg::COND_LIST_DONE: cond_true = list_done;
            gmma_pkg::COND_SWEEP_END: cond_true = sweep_end;
            default:                  cond_true = 1'b0;
        endcase
    end

    // result produced by the current step
    always_comb begin
        emit_want = 1'b0;
        e_kind    = gmma_pkg::KIND_TAKE;
        e_row     = '0;
        e_col     = '0;
        e_score   = '0;
        e_found   = 1'b0;
        e_acc     = 1'b0;
        e_last    = 1'b1;
        unique case (uw.act)
            gmma_pkg::ACT_TAKE: begin
                emit_want = 1'b1;
                e_row     = r_row;
                e_col     = r_col;
                e_acc     = take_ok;
            end
            gmma_pkg::ACT_BEST_EMIT: begin
                emit_want = 1'b1;
                e_kind    = gmma_pkg::KIND_BEST;
                e_row     = r_br;
                e_col     = r_bc;
                e_score   = r_best;
                e_found   = r_hit;
            end
            gmma_pkg::ACT_LIST_STEP: begin
                emit_want = !list_done && cur_free;
                e_kind    = list_col ? gmma_pkg::KIND_FREE_COL : gmma_pkg::KIND_FREE_ROW;
                e_row     = list_col ? '0 : IW'(r_i);
                e_col     = list_col ? IW'(r_i) : '0;
                e_found   = 1'b1;
                e_last    = (r_k == KW'(gmma_pkg::LIST_LIMIT - 1)) ||
                            !(list_col ? col_more : row_more);
            end
            gmma_pkg::ACT_LIST_END: begin
                // empty list gives one result with found low
                emit_want = (r_k == '0);
                e_kind    = list_col ? gmma_pkg::KIND_FREE_COL : gmma_pkg::KIND_FREE_ROW;
            end
            default: begin
                emit_want = 1'b0;
            end
        endcase
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign stall     = emit_want && !out_free;
    assign fire      = emit_want && out_free;
    assign take_fire = (uw.act == gmma_pkg::ACT_TAKE) && fire;

    // next step
    always_comb begin
        n_pc = r_pc;
        if (!stall) begin
            unique case (uw.nxt)
                gmma_pkg::NX_SEQ:  n_pc = r_pc + 1'b1;
                gmma_pkg::NX_JUMP: n_pc = uw.target;
                gmma_pkg::NX_DISP: n_pc = in_fire ? gmma_pkg::dispatch(i_opcode) : r_pc;
                gmma_pkg::NX_LOOP: n_pc = cond_true ? uw.target : r_pc;
                default:           n_pc = gmma_pkg::PC_IDLE;
            endcase
        end
    end

    // score ram: item writes and the clearing sweep share the write port
    assign ram_we    = ((uw.act == gmma_pkg::ACT_WRITE) && wr_in_store) ||
                       (uw.act == gmma_pkg::ACT_CLR_SWEEP);
    assign ram_waddr = (uw.act == gmma_pkg::ACT_CLR_SWEEP) ? r_addr : wr_addr;
    assign ram_wdata = (uw.act == gmma_pkg::ACT_CLR_SWEEP) ? r_floor : r_score;

    gmma_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (scan_addr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= gmma_pkg::PC_CLR_INIT;   // clearing pass after reset
            r_rows      <= gmma_pkg::ROWS_RESET;
            r_cols      <= gmma_pkg::COLS_RESET;
            r_floor     <= gmma_pkg::FLOOR_RESET;
            r_row_taken <= '0;
            r_col_taken <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gmma_pkg::CFG_ROWS:  r_rows  <= i_cfg_data[NW-1:0];
                    gmma_pkg::CFG_COLS:  r_cols  <= i_cfg_data[NW-1:0];
                    gmma_pkg::CFG_FLOOR: r_floor <= i_cfg_data;
                    default: ;
                endcase
            end

            if (uw.act == gmma_pkg::ACT_CLR_INIT) begin
                r_row_taken <= '0;
                r_col_taken <= '0;
            end else if (take_fire && take_ok) begin
                r_row_taken[take_row] <= 1'b1;
                r_col_taken[take_col] <= 1'b1;
            end

            // cell issued this cycle is compared next cycle
            r_pv <= (uw.act == gmma_pkg::ACT_SCAN) && !scan_done && cell_ok;

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_opcode;
            r_row   <= i_row_index;
            r_col   <= i_col_index;
            r_score <= i_score_in;
        end

        r_pi <= IW'(r_i);
        r_pj <= IW'(r_j);

        if (uw.act == gmma_pkg::ACT_BEST_INIT) begin
            r_best <= r_floor;
            r_br   <= '0;
            r_bc   <= '0;
            r_hit  <= 1'b0;
        end else if (r_pv && (rd_score > r_best)) begin
            // strict compare keeps the first maximum in scan order
            r_best <= rd_score;
            r_br   <= r_pi;
            r_bc   <= r_pj;
            r_hit  <= 1'b1;
        end

        unique case (uw.act)
            gmma_pkg::ACT_BEST_INIT: begin
                r_i <= '0;
                r_j <= '0;
            end
            gmma_pkg::ACT_SCAN: begin
                if (!scan_done) begin
                    if (j_last) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            gmma_pkg::ACT_LIST_INIT: begin
                r_i <= '0;
                r_k <= '0;
            end
            gmma_pkg::ACT_LIST_STEP: begin
                if (!list_done && !stall) begin
                    r_i <= r_i + 1'b1;
                    if (fire) begin
                        r_k <= r_k + 1'b1;
                    end
                end
            end
            gmma_pkg::ACT_CLR_INIT: begin
                r_addr <= '0;
            end
            gmma_pkg::ACT_CLR_SWEEP: begin
                r_addr <= r_addr + 1'b1;
            end
            default: ;
        endcase

        if (fire) begin
            r_kind   <= e_kind;
            r_orow   <= e_row;
            r_ocol   <= e_col;
            r_oscore <= e_score;
            r_found  <= e_found;
            r_acc    <= e_acc;
            r_last   <= e_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_out_row     = r_orow;
    assign o_out_col     = r_ocol;
    assign o_out_score   = r_oscore;
    assign o_found       = r_found;
    assign o_accepted    = r_acc;
    assign o_last        = r_last;

    // an accepted take leaves both marks set
    a_take_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take_fire && take_ok) |=>
            (r_row_taken[$past(take_row)] && r_col_taken[$past(take_col)]))
        else $error("take did not set its marks");

    // the list walk never gives more results than the limit
    a_list_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == gmma_pkg::PC_LIST_STEP) |-> (r_k <= KW'(gmma_pkg::LIST_LIMIT)))
        else $error("free list count beyond limit");

    // a compare is pending only right after a scan step
    a_pv_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> ($past(r_pc) == gmma_pkg::PC_SCAN))
        else $error("compare stage valid outside scan");

endmodule

/* rtl/gmma_ram.sv */
// gmma_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module gmma_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
